### design/esc_tce_pkg.sv
// Shared types, constants and helpers of the ESC throttle command encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package esc_tce_pkg;

   // Command kinds, also the protocol register codes
   localparam logic [1:0] KIND_TIMER  = 2'd0;
   localparam logic [1:0] KIND_DSHOT  = 2'd1;
   localparam logic [1:0] KIND_DDSHOT = 2'd2;

   localparam logic [16:0] FULL_Q16     = 17'd65536;
   localparam logic [10:0] DSHOT_MAX    = 11'd2047;
   localparam logic [9:0]  DDSHOT_MAX   = 10'd1023;
   localparam logic [6:0]  IDLE_MAX     = 7'd100;
   localparam logic [16:0] QUOPA_MAX_T  = 17'd9830;
   localparam logic [16:0] CAL_LOW_MAX_T = 17'd6553;
   // ceil(2^24 / 100): exact divide by 100 for dividends up to 102300
   localparam logic [17:0] RECIP_100    = 18'd167773;

   typedef struct packed {
      logic [1:0]  protocol;
      logic [6:0]  idle_percent;
      logic [15:0] pulse_range;
      logic [15:0] idle_pulse;
      logic [15:0] disarm_pulse;
      logic [15:0] disarm_pulse_3d;
      logic [15:0] calibrate_pulse;
      logic [15:0] calibrate_full_pulse;
   } cfg_type;

   // Mode flags that ride along with every item
   typedef struct packed {
      logic armed;
      logic calibrate;
      logic three_d;
      logic lead_low;
   } mode_type;

   // Quantizer output beat
   typedef struct packed {
      logic [16:0] throttle;
      logic        quopa_limit;
      mode_type    mode;
   } thr_type;

   // Multiplier output beat
   typedef struct packed {
      logic [15:0] timer_value;
      logic [15:0] frame;
      logic [32:0] dd_num;
      mode_type    mode;
   } prod_type;

   function automatic logic [6:0] idle_sat(input logic [6:0] idle);
      idle_sat = (idle > IDLE_MAX) ? IDLE_MAX : idle;
   endfunction

   function automatic logic [1:0] kind_of(input logic [1:0] protocol);
      kind_of = (protocol == KIND_DSHOT || protocol == KIND_DDSHOT) ? protocol : KIND_TIMER;
   endfunction

endpackage

### design/esc_tce_csr.sv
// Configuration register file with an APB-style slave port.
// Depends on esc_tce_pkg for the register struct.
`timescale 1ns / 1ps

module esc_tce_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output esc_tce_pkg::cfg_type cfg
);

   localparam logic [2:0] REG_PROTOCOL     = 3'd0;
   localparam logic [2:0] REG_IDLE_PERCENT = 3'd1;
   localparam logic [2:0] REG_PULSE_RANGE  = 3'd2;
   localparam logic [2:0] REG_IDLE_PULSE   = 3'd3;
   localparam logic [2:0] REG_DISARM       = 3'd4;
   localparam logic [2:0] REG_DISARM_3D    = 3'd5;
   localparam logic [2:0] REG_CAL          = 3'd6;
   localparam logic [2:0] REG_CAL_FULL     = 3'd7;

   esc_tce_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PROTOCOL:     cfg_in.protocol             = pwdata[1:0];
            REG_IDLE_PERCENT: cfg_in.idle_percent         = pwdata[6:0];
            REG_PULSE_RANGE:  cfg_in.pulse_range          = pwdata[15:0];
            REG_IDLE_PULSE:   cfg_in.idle_pulse           = pwdata[15:0];
            REG_DISARM:       cfg_in.disarm_pulse         = pwdata[15:0];
            REG_DISARM_3D:    cfg_in.disarm_pulse_3d      = pwdata[15:0];
            REG_CAL:          cfg_in.calibrate_pulse      = pwdata[15:0];
            REG_CAL_FULL:     cfg_in.calibrate_full_pulse = pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         REG_PROTOCOL:     prdata = {30'd0, cfg_ff.protocol};
         REG_IDLE_PERCENT: prdata = {25'd0, cfg_ff.idle_percent};
         REG_PULSE_RANGE:  prdata = {16'd0, cfg_ff.pulse_range};
         REG_IDLE_PULSE:   prdata = {16'd0, cfg_ff.idle_pulse};
         REG_DISARM:       prdata = {16'd0, cfg_ff.disarm_pulse};
         REG_DISARM_3D:    prdata = {16'd0, cfg_ff.disarm_pulse_3d};
         REG_CAL:          prdata = {16'd0, cfg_ff.calibrate_pulse};
         REG_CAL_FULL:     prdata = {16'd0, cfg_ff.calibrate_full_pulse};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/esc_tce_quant.sv
// Pipeline segment 1: throttle saturation and optional 1/255 quantization.
// Two register stages; depends on esc_tce_pkg.
`timescale 1ns / 1ps

module esc_tce_quant (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [16:0]          throttle,
   input  logic [16:0]          lead_throttle,
   input  logic                 armed,
   input  logic                 calibrate,
   input  logic                 three_d,
   input  logic                 quopa_limit,
   input  logic                 res_redux,
   output logic                 out_valid,
   input  logic                 out_stall,
   output esc_tce_pkg::thr_type out_beat
);

   logic        v1_ff, v2_ff;
   logic        en1, en2;
   logic [16:0] t_sat, l_sat;
   logic [24:0] t_scaled, l_scaled;

   // stage 1 payload
   logic [16:0] t1_ff, l1_ff;
   logic [7:0]  tq1_ff, lq1_ff;
   logic        redux1_ff, armed1_ff, cal1_ff, td1_ff, quopa1_ff;
   logic [16:0] t_fin, l_fin;
   esc_tce_pkg::thr_type beat2_in, beat2_ff;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   // Saturate and take round(t * 255 / 65536)
   always_comb begin
      t_sat    = (throttle > esc_tce_pkg::FULL_Q16) ? esc_tce_pkg::FULL_Q16 : throttle;
      l_sat    = (lead_throttle > esc_tce_pkg::FULL_Q16) ? esc_tce_pkg::FULL_Q16 : lead_throttle;
      t_scaled = {t_sat, 8'd0} - {8'd0, t_sat} + 25'd32768;
      l_scaled = {l_sat, 8'd0} - {8'd0, l_sat} + 25'd32768;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         t1_ff     <= t_sat;
         l1_ff     <= l_sat;
         tq1_ff    <= t_scaled[23:16];
         lq1_ff    <= l_scaled[23:16];
         redux1_ff <= res_redux;
         armed1_ff <= armed;
         cal1_ff   <= calibrate;
         td1_ff    <= three_d;
         quopa1_ff <= quopa_limit;
      end
   end

   // Back to Q0.16: (q*65536+127)/255 = q*257 + (q >= 128)
   always_comb begin
      t_fin = redux1_ff ? ({1'b0, tq1_ff, 8'd0} + {9'd0, tq1_ff} + {16'd0, tq1_ff[7]})
                        : t1_ff;
      l_fin = redux1_ff ? ({1'b0, lq1_ff, 8'd0} + {9'd0, lq1_ff} + {16'd0, lq1_ff[7]})
                        : l1_ff;
      beat2_in.throttle       = t_fin;
      beat2_in.quopa_limit    = quopa1_ff;
      beat2_in.mode.armed     = armed1_ff;
      beat2_in.mode.calibrate = cal1_ff;
      beat2_in.mode.three_d   = td1_ff;
      beat2_in.mode.lead_low  = (l_fin <= esc_tce_pkg::CAL_LOW_MAX_T);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         beat2_ff <= beat2_in;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_beat  = beat2_ff;

endmodule

### design/esc_tce_mult.sv
// Pipeline segment 2: throttle products, timer value, DShot frame and
// DDShot numerator. Two register stages; depends on esc_tce_pkg.
`timescale 1ns / 1ps

module esc_tce_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  esc_tce_pkg::cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  esc_tce_pkg::thr_type  in_beat,
   output logic                  out_valid,
   input  logic                  out_stall,
   output esc_tce_pkg::prod_type out_beat
);

   logic        v1_ff, v2_ff;
   logic        en1, en2;
   logic [6:0]  idle;
   logic [11:0] lo_raw;
   logic [10:0] lo, span;
   logic [32:0] pw_prod;
   logic [27:0] ds_prod;
   logic [23:0] m_sum;

   logic [16:0] pw_hi_ff;
   logic [10:0] ds_hi_ff;
   logic [22:0] m_ff;
   logic        quopa_zero_ff;
   esc_tce_pkg::mode_type mode1_ff;

   logic [11:0] v_sum;
   logic [10:0] v_cap;
   logic [11:0] d_val;
   logic [3:0]  csum;
   esc_tce_pkg::prod_type beat2_in, beat2_ff;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   // DShot low end: 48 + 20 * idle, capped at 2047
   always_comb begin
      idle   = esc_tce_pkg::idle_sat(cfg.idle_percent);
      lo_raw = 12'd48 + ({5'd0, idle} << 4) + ({5'd0, idle} << 2);
      lo     = (lo_raw > {1'b0, esc_tce_pkg::DSHOT_MAX}) ? esc_tce_pkg::DSHOT_MAX
                                                          : lo_raw[10:0];
      span   = esc_tce_pkg::DSHOT_MAX - lo;
   end

   // Stage 1: the three multiplies
   always_comb begin
      pw_prod = {16'd0, in_beat.throttle} * {17'd0, cfg.pulse_range};
      ds_prod = {11'd0, in_beat.throttle} * {17'd0, span};
      m_sum   = {1'b0, idle, 16'd0}
              + ({7'd0, in_beat.throttle} * {17'd0, esc_tce_pkg::IDLE_MAX - idle});
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pw_hi_ff      <= pw_prod[32:16];
         ds_hi_ff      <= ds_prod[26:16];
         m_ff          <= m_sum[22:0];
         quopa_zero_ff <= in_beat.quopa_limit
                          && (in_beat.throttle <= esc_tce_pkg::QUOPA_MAX_T);
         mode1_ff      <= in_beat.mode;
      end
   end

   // Stage 2: timer add, frame with nibble-xor checksum, DDShot numerator
   always_comb begin
      v_sum = {1'b0, lo} + {1'b0, ds_hi_ff};
      v_cap = (v_sum > {1'b0, esc_tce_pkg::DSHOT_MAX}) ? esc_tce_pkg::DSHOT_MAX
                                                        : v_sum[10:0];
      d_val = (idle == 7'd0 || quopa_zero_ff) ? 12'd0 : {v_cap, 1'b0};
      csum  = d_val[3:0] ^ d_val[7:4] ^ d_val[11:8];
      beat2_in.timer_value = pw_hi_ff[15:0] + cfg.idle_pulse;
      beat2_in.frame       = {d_val, csum};
      beat2_in.dd_num      = {m_ff, 10'd0} - {10'd0, m_ff};
      beat2_in.mode        = mode1_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         beat2_ff <= beat2_in;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_beat  = beat2_ff;

endmodule

### design/esc_tce_round.sv
// Pipeline segment 3: DDShot divide by 6553600 with half-even rounding,
// command select and the output register. Depends on esc_tce_pkg.
`timescale 1ns / 1ps

module esc_tce_round (
   input  logic                  clock,
   input  logic                  reset,
   input  esc_tce_pkg::cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  esc_tce_pkg::prod_type in_beat,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [15:0]           command_value,
   output logic [1:0]            command_kind
);

   logic        v1_ff, v2_ff;
   logic        en1, en2;
   logic [16:0] hi;
   logic [34:0] recip_prod;

   logic [16:0] hi1_ff;
   logic [9:0]  q1_ff;
   logic        lo_nz1_ff;
   logic [15:0] timer1_ff, frame1_ff;
   esc_tce_pkg::mode_type mode1_ff;

   logic [16:0] r_full;
   logic [6:0]  rem;
   logic        round_up;
   logic [10:0] q_rnd;
   logic [9:0]  dd_val;
   logic [1:0]  kind;
   logic        has_result;
   logic [15:0] value_in, value_ff;
   logic [1:0]  kind_ff;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   // Stage 1: quotient of (num >> 16) / 100 by reciprocal multiply
   always_comb begin
      hi         = in_beat.dd_num[32:16];
      recip_prod = {18'd0, hi} * {17'd0, esc_tce_pkg::RECIP_100};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         hi1_ff    <= hi;
         q1_ff     <= recip_prod[33:24];
         lo_nz1_ff <= (in_beat.dd_num[15:0] != 16'd0);
         timer1_ff <= in_beat.timer_value;
         frame1_ff <= in_beat.frame;
         mode1_ff  <= in_beat.mode;
      end
   end

   // Stage 2: remainder, half-even rounding, command select
   always_comb begin
      r_full   = hi1_ff - ({7'd0, q1_ff} * 17'd100);
      rem      = r_full[6:0];
      round_up = (rem > 7'd50) || (rem == 7'd50 && (lo_nz1_ff || q1_ff[0]));
      q_rnd    = {1'b0, q1_ff} + {10'd0, round_up};
      dd_val   = (q_rnd > {1'b0, esc_tce_pkg::DDSHOT_MAX}) ? esc_tce_pkg::DDSHOT_MAX
                                                            : q_rnd[9:0];
      kind       = esc_tce_pkg::kind_of(cfg.protocol);
      has_result = mode1_ff.armed || !mode1_ff.calibrate
                   || (kind == esc_tce_pkg::KIND_TIMER);
      priority if (mode1_ff.armed) begin
         unique case (kind)
            esc_tce_pkg::KIND_DDSHOT:
               value_in = (cfg.idle_percent == 7'd0) ? 16'd0 : {6'd0, dd_val};
            esc_tce_pkg::KIND_DSHOT: value_in = frame1_ff;
            default:                 value_in = timer1_ff;
         endcase
      end else if (mode1_ff.calibrate) begin
         value_in = mode1_ff.lead_low ? cfg.calibrate_pulse : cfg.calibrate_full_pulse;
      end else if (kind != esc_tce_pkg::KIND_TIMER) begin
         value_in = 16'd0;
      end else begin
         value_in = mode1_ff.three_d ? cfg.disarm_pulse_3d : cfg.disarm_pulse;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en2) begin
         value_ff <= value_in;
         kind_ff  <= kind;
      end
   end

   // Valid bits; a beat without a result is dropped here
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff && has_result;
      end
   end

   assign out_valid     = v2_ff;
   assign command_value = value_ff;
   assign command_kind  = kind_ff;

endmodule

### design/esc_throttle_command_encoder_unit.sv
// Top level of the ESC throttle command encoder: CSR block plus three
// pipeline segments. Depends on esc_tce_pkg, esc_tce_csr, esc_tce_quant,
// esc_tce_mult and esc_tce_round.
//
// Usage:
//  - req_* channel takes one beat per motor: throttle and lead_throttle as
//    Q0.16 (65536 is full), plus armed, calibrate, three_d, quopa_limit and
//    res_redux. rsp_* channel returns command_value and command_kind.
//  - A beat is accepted when valid is high and stall is low on that channel.
//  - Throughput is one beat per cycle while rsp_stall is low; the six register
//    stages are the two quantizer stages, the two multiplier stages, the
//    reciprocal divide and the output register.
//  - Calibrate while disarmed with a DShot or DDShot protocol yields no
//    response beat; that request is consumed silently.
//  - rsp_stall holds the output register; upstream stages keep filling any
//    empty slots, and req_stall rises only when all six stages are full.
//  - Reset (synchronous) empties the pipeline and clears the configuration registers to 0.
//  - Registers are written over the APB port at byte address 4*index and
//    should only change while no request is in flight.
`timescale 1ns / 1ps

module esc_throttle_command_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [16:0] req_throttle,
   input  logic [16:0] req_lead_throttle,
   input  logic        req_armed,
   input  logic        req_calibrate,
   input  logic        req_three_d,
   input  logic        req_quopa_limit,
   input  logic        req_res_redux,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_command_value,
   output logic [1:0]  rsp_command_kind,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   esc_tce_pkg::cfg_type  cfg;
   esc_tce_pkg::thr_type  thr_beat;
   esc_tce_pkg::prod_type prod_beat;
   logic thr_valid, thr_stall;
   logic prod_valid, prod_stall;

   esc_tce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   esc_tce_quant u_quant (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .throttle      (req_throttle),
      .lead_throttle (req_lead_throttle),
      .armed         (req_armed),
      .calibrate     (req_calibrate),
      .three_d       (req_three_d),
      .quopa_limit   (req_quopa_limit),
      .res_redux     (req_res_redux),
      .out_valid     (thr_valid),
      .out_stall     (thr_stall),
      .out_beat      (thr_beat)
   );

   esc_tce_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (thr_valid),
      .in_stall  (thr_stall),
      .in_beat   (thr_beat),
      .out_valid (prod_valid),
      .out_stall (prod_stall),
      .out_beat  (prod_beat)
   );

   esc_tce_round u_round (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (prod_valid),
      .in_stall      (prod_stall),
      .in_beat       (prod_beat),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .command_value (rsp_command_value),
      .command_kind  (rsp_command_kind)
   );

   // Back-pressure reaches the input only when the output itself is held
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled response");

   // DShot frames carry a consistent nibble-xor checksum
   a_frame_csum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_kind == esc_tce_pkg::KIND_DSHOT) |->
      (rsp_command_value[3:0] == (rsp_command_value[7:4] ^ rsp_command_value[11:8]
                                  ^ rsp_command_value[15:12])))
      else $error("bad DShot checksum");

   // DDShot values stay within 10 bits
   a_ddshot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command_kind == esc_tce_pkg::KIND_DDSHOT) |->
      (rsp_command_value[15:10] == 6'd0))
      else $error("DDShot value out of range");

endmodule

### verif/tb_esc_throttle_command_encoder_unit.sv
// Self-checking testbench for esc_throttle_command_encoder_unit: predicts each
// command from the throttle beat and the register shadow, checks every response.
// Depends on esc_tce_pkg and the RTL of the encoder.
`timescale 1ns / 1ps

module tb_esc_throttle_command_encoder_unit;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;     // pipeline is 6 deep, leave margin
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int RANDOM_PHASES = 10;
   localparam int BEATS_PER_PHASE = 125;

   typedef enum logic [2:0] {
      REG_PROTOCOL, REG_IDLE_PERCENT, REG_PULSE_RANGE, REG_IDLE_PULSE,
      REG_DISARM_PULSE, REG_DISARM_PULSE_3D, REG_CAL_PULSE, REG_CAL_FULL_PULSE
   } csr_index_type;

   typedef struct packed {
      logic [16:0] throttle;
      logic [16:0] lead;
      logic        armed;
      logic        calibrate;
      logic        three_d;
      logic        quopa_limit;
      logic        res_redux;
   } throttle_beat_type;

   typedef struct packed {
      logic [15:0] value;
      logic [1:0]  kind;
   } command_type;

   // DUT signals; the inputs are all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [16:0] req_throttle = '0;
   logic [16:0] req_lead_throttle = '0;
   logic        req_armed = 1'b0;
   logic        req_calibrate = 1'b0;
   logic        req_three_d = 1'b0;
   logic        req_quopa_limit = 1'b0;
   logic        req_res_redux = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_command_value;
   logic [1:0]  rsp_command_kind;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Testbench state
   throttle_beat_type    throttle_beat_q[$];
   command_type          command_expect_q[$];
   throttle_beat_type    offered_beat;
   command_type          predicted_cmd;
   command_type          wanted_cmd;
   esc_tce_pkg::cfg_type csr_shadow = '0;
   logic           tx_gap_on = 1'b0;
   logic           rx_idle_on = 1'b0;
   logic           hold_armed = 1'b0;
   logic           rx_hold = 1'b0;
   int             hold_count = 0;
   int             tx_gap_left = 0;
   int             stall_left = 0;
   int             cycle_count = 0;
   int             fail_count = 0;
   int             req_beat_count = 0;
   int             rsp_beat_count = 0;
   int             settings_count = 0;

   esc_throttle_command_encoder_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_throttle      (req_throttle),
      .req_lead_throttle (req_lead_throttle),
      .req_armed         (req_armed),
      .req_calibrate     (req_calibrate),
      .req_three_d       (req_three_d),
      .req_quopa_limit   (req_quopa_limit),
      .req_res_redux     (req_res_redux),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_value (rsp_command_value),
      .rsp_command_kind  (rsp_command_kind),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [16:0] clamp_full(input logic [16:0] v);
      return (v > esc_tce_pkg::FULL_Q16) ? esc_tce_pkg::FULL_Q16 : v;
   endfunction

   // round to 1/255 steps and back to Q0.16
   function automatic logic [16:0] step_255(input logic [16:0] t);
      logic [63:0] q;
      logic [63:0] back;
      q = (64'(t) * 64'd255 + 64'd32768) >> 16;
      back = (q * 64'd65536 + 64'd127) / 64'd255;
      return back[16:0];
   endfunction

   function automatic logic [6:0] cap_idle(input logic [6:0] idle);
      return (idle > esc_tce_pkg::IDLE_MAX) ? esc_tce_pkg::IDLE_MAX : idle;
   endfunction

   function automatic logic [15:0] dshot_word(input logic [16:0] t, input logic [6:0] idle_raw,
                                              input logic quopa);
      logic [31:0] idle;
      logic [31:0] lo;
      logic [31:0] v;
      logic [31:0] d;
      logic [63:0] prod;
      logic [3:0]  csum;
      idle = 32'(cap_idle(idle_raw));
      d = '0;
      if (idle != 32'd0) begin
         lo = 32'd48 + 32'd20 * idle;
         if (lo > 32'(esc_tce_pkg::DSHOT_MAX)) lo = 32'(esc_tce_pkg::DSHOT_MAX);
         prod = 64'(t) * 64'(32'(esc_tce_pkg::DSHOT_MAX) - lo);
         v = lo + 32'(prod >> 16);
         if (v > 32'(esc_tce_pkg::DSHOT_MAX)) v = 32'(esc_tce_pkg::DSHOT_MAX);
         d = v << 1;
      end
      // low-throttle cutoff lands before the checksum
      if (quopa && t <= esc_tce_pkg::QUOPA_MAX_T) d = '0;
      csum = 4'((d ^ (d >> 4) ^ (d >> 8)) & 32'hF);
      return 16'((d << 4) | 32'(csum));
   endfunction

   function automatic logic [15:0] ddshot_level(input logic [16:0] t, input logic [6:0] idle_raw);
      logic [63:0] idle;
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      idle = 64'(cap_idle(idle_raw));
      if (idle == 64'd0) return 16'd0;
      num = 64'(esc_tce_pkg::DDSHOT_MAX) * (idle * 64'd65536 + 64'(t) * (64'd100 - idle));
      q = num / 64'd6553600;
      r = num % 64'd6553600;
      // round half to even
      if (64'd2 * r > 64'd6553600 || (64'd2 * r == 64'd6553600 && q[0])) q++;
      if (q > 64'(esc_tce_pkg::DDSHOT_MAX)) q = 64'(esc_tce_pkg::DDSHOT_MAX);
      return 16'(q);
   endfunction

   // returns 0 when the beat produces no command
   function automatic logic encode_command(input esc_tce_pkg::cfg_type cfg,
                                           input throttle_beat_type b,
                                           output command_type cmd);
      logic [16:0] t;
      logic [16:0] lead;
      logic [1:0]  kind;
      logic [63:0] prod;
      t = clamp_full(b.throttle);
      lead = clamp_full(b.lead);
      kind = (cfg.protocol == esc_tce_pkg::KIND_DSHOT
              || cfg.protocol == esc_tce_pkg::KIND_DDSHOT) ?
             cfg.protocol : esc_tce_pkg::KIND_TIMER;
      if (b.res_redux) begin
         t = step_255(t);
         lead = step_255(lead);
      end
      cmd.kind = kind;
      cmd.value = '0;
      encode_command = 1'b1;
      if (b.armed) begin
         case (kind)
            esc_tce_pkg::KIND_DDSHOT: cmd.value = ddshot_level(t, cfg.idle_percent);
            esc_tce_pkg::KIND_DSHOT:
               cmd.value = dshot_word(t, cfg.idle_percent, b.quopa_limit);
            default: begin
               prod = 64'(t) * 64'(cfg.pulse_range);
               cmd.value = 16'((prod >> 16) + 64'(cfg.idle_pulse));
            end
         endcase
      end else if (b.calibrate) begin
         if (kind != esc_tce_pkg::KIND_TIMER) encode_command = 1'b0;
         cmd.value = (lead <= esc_tce_pkg::CAL_LOW_MAX_T) ? cfg.calibrate_pulse
                                                          : cfg.calibrate_full_pulse;
      end else if (kind == esc_tce_pkg::KIND_TIMER) begin
         cmd.value = b.three_d ? cfg.disarm_pulse_3d : cfg.disarm_pulse;
      end
   endfunction

   // ---------------------------------------------------------------- random helpers

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [16:0] pick_throttle();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return esc_tce_pkg::FULL_Q16;
         2: return 17'($urandom_range(65537, 131071));
         3: return esc_tce_pkg::QUOPA_MAX_T - 17'd2 + 17'($urandom_range(0, 4));
         4: return esc_tce_pkg::CAL_LOW_MAX_T - 17'd2 + 17'($urandom_range(0, 4));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            req_beat_count++;
            if (encode_command(csr_shadow, offered_beat, predicted_cmd))
               command_expect_q.push_back(predicted_cmd);
         end
         // payload holds while stalled
         if (!req_valid || !req_stall) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_valid <= 1'b0;
            end else if (throttle_beat_q.size() > 0) begin
               offered_beat = throttle_beat_q.pop_front();
               req_throttle <= offered_beat.throttle;
               req_lead_throttle <= offered_beat.lead;
               req_armed <= offered_beat.armed;
               req_calibrate <= offered_beat.calibrate;
               req_three_d <= offered_beat.three_d;
               req_quopa_limit <= offered_beat.quopa_limit;
               req_res_redux <= offered_beat.res_redux;
               req_valid <= 1'b1;
               tx_gap_left = tx_gap_on ? idle_len() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beat_count++;
            if (command_expect_q.size() == 0) begin
               $display("%0t unexpected command beat: expected none, actual value %h kind %0d",
                        $time, rsp_command_value, rsp_command_kind);
               fail_count++;
            end else begin
               wanted_cmd = command_expect_q.pop_front();
               if (rsp_command_value !== wanted_cmd.value) begin
                  $display("%0t command_value mismatch: expected %h actual %h",
                           $time, wanted_cmd.value, rsp_command_value);
                  fail_count++;
               end
               if (rsp_command_kind !== wanted_cmd.kind) begin
                  $display("%0t command_kind mismatch: expected %0d actual %0d",
                           $time, wanted_cmd.kind, rsp_command_kind);
                  fail_count++;
               end
            end
         end
         // random back-pressure plus the long hold-off
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (rx_idle_on) stall_left = idle_len();
            rsp_stall <= rx_hold;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         rx_hold <= 1'b0;
         hold_count <= 0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         rx_hold <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rx_hold <= 1'b0;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("[esc_throttle_command_encoder_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequencing

   task automatic csr_write(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_csr(input esc_tce_pkg::cfg_type c);
      csr_write(REG_PROTOCOL, 32'(c.protocol));
      csr_write(REG_IDLE_PERCENT, 32'(c.idle_percent));
      csr_write(REG_PULSE_RANGE, 32'(c.pulse_range));
      csr_write(REG_IDLE_PULSE, 32'(c.idle_pulse));
      csr_write(REG_DISARM_PULSE, 32'(c.disarm_pulse));
      csr_write(REG_DISARM_PULSE_3D, 32'(c.disarm_pulse_3d));
      csr_write(REG_CAL_PULSE, 32'(c.calibrate_pulse));
      csr_write(REG_CAL_FULL_PULSE, 32'(c.calibrate_full_pulse));
      csr_shadow = c;
      settings_count++;
   endtask

   task automatic add_beat(input logic [16:0] thr, input logic [16:0] lead, input logic armed,
                           input logic cal, input logic three_d, input logic quopa,
                           input logic redux);
      throttle_beat_q.push_back('{thr, lead, armed, cal, three_d, quopa, redux});
   endtask

   // everything sent and answered, then let the pipeline run dry;
   // sampled mid-cycle so the driver's edge updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (throttle_beat_q.size() != 0 || req_valid || command_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      esc_tce_pkg::cfg_type cfg;
      throttle_beat_type b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset
      add_beat(17'd50000, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_drained();

      // pulse width: extremes, saturation, wrap, disarm and calibration thresholds
      cfg = '{esc_tce_pkg::KIND_TIMER, 7'd10, 16'd40000, 16'd30000, 16'd900, 16'd1500,
              16'd1000, 16'd2000};
      load_csr(cfg);
      add_beat(17'd0, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(esc_tce_pkg::FULL_Q16, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(17'h1FFFF, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(17'd12345, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      add_beat(17'd30000, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(17'd30000, 17'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      add_beat(17'd0, esc_tce_pkg::CAL_LOW_MAX_T, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      add_beat(17'd0, esc_tce_pkg::CAL_LOW_MAX_T + 17'd1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      add_beat(17'd0, 17'h1FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      add_beat(17'd0, 17'd6580, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      wait_drained();

      // DShot with zero idle forces frame 0
      cfg.protocol = esc_tce_pkg::KIND_DSHOT;
      cfg.idle_percent = 7'd0;
      load_csr(cfg);
      add_beat(17'd40000, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(17'd40000, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_drained();

      // DShot range, quopa cutoff, calibrate gives nothing
      cfg.idle_percent = 7'd37;
      load_csr(cfg);
      add_beat(17'd0, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(esc_tce_pkg::FULL_Q16, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(esc_tce_pkg::QUOPA_MAX_T, 17'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      add_beat(esc_tce_pkg::QUOPA_MAX_T + 17'd1, 17'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      add_beat(17'h1FFFF, 17'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      add_beat(17'd20000, 17'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      add_beat(17'd20000, 17'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      wait_drained();

      // DDShot with idle above hundred
      cfg.protocol = esc_tce_pkg::KIND_DDSHOT;
      cfg.idle_percent = 7'd127;
      load_csr(cfg);
      add_beat(17'd0, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(esc_tce_pkg::FULL_Q16, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(17'd33333, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      add_beat(17'd33333, 17'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      add_beat(17'd33333, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_drained();

      // unused protocol code behaves as pulse width
      cfg.protocol = 2'd3;
      cfg.idle_percent = 7'd55;
      load_csr(cfg);
      add_beat(17'd20000, 17'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      wait_drained();

      // random phases, each with fresh registers
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cfg.protocol = 2'(p % 4);
         case ($urandom_range(0, 5))
            0: cfg.idle_percent = 7'd0;
            1: cfg.idle_percent = 7'd1;
            2: cfg.idle_percent = esc_tce_pkg::IDLE_MAX;
            3: cfg.idle_percent = 7'd127;
            default: cfg.idle_percent = 7'($urandom_range(0, 127));
         endcase
         cfg.pulse_range = pick16();
         cfg.idle_pulse = pick16();
         cfg.disarm_pulse = pick16();
         cfg.disarm_pulse_3d = pick16();
         cfg.calibrate_pulse = pick16();
         cfg.calibrate_full_pulse = pick16();
         if (p == 8) begin
            cfg.pulse_range = '0;
            cfg.idle_pulse = '0;
            cfg.disarm_pulse = '0;
            cfg.disarm_pulse_3d = '0;
            cfg.calibrate_pulse = '0;
            cfg.calibrate_full_pulse = '0;
         end else if (p == 9) begin
            cfg.pulse_range = 16'hFFFF;
            cfg.idle_pulse = 16'hFFFF;
            cfg.disarm_pulse = 16'hFFFF;
            cfg.disarm_pulse_3d = 16'hFFFF;
            cfg.calibrate_pulse = 16'hFFFF;
            cfg.calibrate_full_pulse = 16'hFFFF;
         end
         load_csr(cfg);

         // phase 0 runs flat out, phase 3 fills the pipe against a held receiver
         @(posedge clock);
         tx_gap_on <= (p != 0 && p != 3);
         rx_idle_on <= (p != 0 && p != 3);
         if (p == 3) hold_armed <= 1'b1;

         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            b.throttle = pick_throttle();
            b.lead = pick_throttle();
            b.armed = ($urandom_range(0, 9) < 6);
            b.calibrate = 1'($urandom_range(0, 1));
            b.three_d = 1'($urandom_range(0, 1));
            b.quopa_limit = 1'($urandom_range(0, 1));
            b.res_redux = 1'($urandom_range(0, 1));
            throttle_beat_q.push_back(b);
         end
         wait_drained();
      end

      $display("run covered %0d request beats and %0d command beats over %0d register settings",
               req_beat_count, rsp_beat_count, settings_count);
      $display("including a %0d-cycle receiver hold-off; %0d mismatches", HOLD_CYCLES, fail_count);
      if (fail_count == 0) begin
         $display("[esc_throttle_command_encoder_unit] OK");
      end else begin
         $display("[esc_throttle_command_encoder_unit] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
design/esc_tce_pkg.sv
design/esc_tce_csr.sv
design/esc_tce_quant.sv
design/esc_tce_mult.sv
design/esc_tce_round.sv
design/esc_throttle_command_encoder_unit.sv
verif/tb_esc_throttle_command_encoder_unit.sv
